// File: hdl/look_at_view_matrix_defines.svh
// assertion macros used by the normaliser of the look-at view matrix rtl
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition must never be seen
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// File: hdl/lvm_pkg.sv
// shared types and constants for the look-at view matrix block
package lvm_pkg;

    localparam int DATA_W            = 32;
    localparam int FRAC_BITS_DEFAULT = 16;
    // the largest scaled magnitude sits in [2^SCALE_MSB, 2^(SCALE_MSB+1))
    localparam int SCALE_MSB         = 29;
    // leading one search works on groups of this many bits
    localparam int GROUP_W           = 8;

    typedef struct packed {
        logic signed [DATA_W-1:0] eye_x;
        logic signed [DATA_W-1:0] eye_y;
        logic signed [DATA_W-1:0] eye_z;
        logic signed [DATA_W-1:0] look_x;
        logic signed [DATA_W-1:0] look_y;
        logic signed [DATA_W-1:0] look_z;
        logic signed [DATA_W-1:0] upward_x;
        logic signed [DATA_W-1:0] upward_y;
        logic signed [DATA_W-1:0] upward_z;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] row0_col0;
        logic signed [DATA_W-1:0] row0_col1;
        logic signed [DATA_W-1:0] row0_col2;
        logic signed [DATA_W-1:0] row0_col3;
        logic signed [DATA_W-1:0] row1_col0;
        logic signed [DATA_W-1:0] row1_col1;
        logic signed [DATA_W-1:0] row1_col2;
        logic signed [DATA_W-1:0] row1_col3;
        logic signed [DATA_W-1:0] row2_col0;
        logic signed [DATA_W-1:0] row2_col1;
        logic signed [DATA_W-1:0] row2_col2;
        logic signed [DATA_W-1:0] row2_col3;
    } result_t;

endpackage

// File: hdl/lvm_norm.sv
// pipelined three-component vector normaliser: scale, square root, divide
`include "look_at_view_matrix_defines.svh"

module lvm_norm
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
    parameter int IN_W      = 33,
    parameter int SIDE_W    = 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [IN_W-1:0]      vec [3],
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+1:0] nvec [3],
    output logic [SIDE_W-1:0]           side_out
);

    localparam int NW  = FRAC_BITS + 2;
    localparam int AW  = SCALE_MSB + 1;
    localparam int NG  = (IN_W + GROUP_W - 1) / GROUP_W;
    localparam int PW  = $clog2(NG * GROUP_W);
    localparam int LW  = $clog2(GROUP_W);
    localparam int SW  = 2 * AW + 2;
    localparam int RW  = AW + 1;
    localparam int NSQ = RW;
    localparam int DR  = AW + 2;
    localparam int QW  = FRAC_BITS + 1;
    localparam int TW  = SIDE_W + 4;
    localparam int CW  = 3 * AW + TW;

    logic [5:0] vf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= '0;
        end
        else if (en)
        begin
            vf_reg <= {vf_reg[4:0], in_valid};
        end
    end

    // stage 1: magnitudes and their or for the leading one search
    logic [IN_W-1:0]   a1_next [3];
    logic [IN_W-1:0]   a1_reg [3];
    logic [2:0]        neg1_reg;
    logic [IN_W-1:0]   or1_reg;
    logic [SIDE_W-1:0] side1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a1_next[i] = vec[i][IN_W-1] ? IN_W'(-vec[i]) : IN_W'(vec[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= a1_next;
            neg1_reg  <= {vec[2][IN_W-1], vec[1][IN_W-1], vec[0][IN_W-1]};
            or1_reg   <= a1_next[0] | a1_next[1] | a1_next[2];
            side1_reg <= side_in;
        end
    end

    // stage 2: leading one within each group
    logic [NG*GROUP_W-1:0] orp;
    logic [NG-1:0]         nz2_next;
    logic [LW-1:0]         lp2_next [NG];
    logic [IN_W-1:0]       a2_reg [3];
    logic [2:0]            neg2_reg;
    logic [NG-1:0]         nz2_reg;
    logic [LW-1:0]         lp2_reg [NG];
    logic [SIDE_W-1:0]     side2_reg;

    always_comb
    begin
        orp = (NG*GROUP_W)'(or1_reg);
        for (int g = 0; g < NG; g++)
        begin
            nz2_next[g] = |orp[g*GROUP_W +: GROUP_W];
            lp2_next[g] = '0;
            for (int b = 0; b < GROUP_W; b++)
            begin
                if (orp[g*GROUP_W+b])
                begin
                    lp2_next[g] = LW'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg    <= a1_reg;
            neg2_reg  <= neg1_reg;
            nz2_reg   <= nz2_next;
            lp2_reg   <= lp2_next;
            side2_reg <= side1_reg;
        end
    end

    // stage 3: top group wins, work out shift direction and distance
    logic [PW-1:0]     lead;
    logic              right3_next;
    logic [PW-1:0]     amt3_next;
    logic [IN_W-1:0]   a3_reg [3];
    logic [2:0]        neg3_reg;
    logic              zero3_reg;
    logic              right3_reg;
    logic [PW-1:0]     amt3_reg;
    logic [SIDE_W-1:0] side3_reg;

    always_comb
    begin
        lead = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (nz2_reg[g])
            begin
                lead = PW'(g * GROUP_W) + PW'(lp2_reg[g]);
            end
        end
        if (lead >= PW'(AW))
        begin
            right3_next = 1'b1;
            amt3_next   = lead - PW'(AW - 1);
        end
        else
        begin
            right3_next = 1'b0;
            amt3_next   = PW'(AW - 1) - lead;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg     <= a2_reg;
            neg3_reg   <= neg2_reg;
            zero3_reg  <= ~|nz2_reg;
            right3_reg <= right3_next;
            amt3_reg   <= amt3_next;
            side3_reg  <= side2_reg;
        end
    end

    // stage 4: common shift of all three magnitudes, right shifts truncate
    logic [IN_W+AW-1:0] wide [3];
    logic [IN_W+AW-1:0] shd [3];
    logic [AW-1:0]      sa4_next [3];
    logic [AW-1:0]      sa4_reg [3];
    logic [2:0]         neg4_reg;
    logic               zero4_reg;
    logic [SIDE_W-1:0]  side4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wide[i]     = (IN_W+AW)'(a3_reg[i]);
            shd[i]      = right3_reg ? (wide[i] >> amt3_reg) : (wide[i] << amt3_reg);
            sa4_next[i] = shd[i][AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa4_reg   <= sa4_next;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            side4_reg <= side3_reg;
        end
    end

    // stage 5: squares, stage 6: sum of squares
    logic [2*AW-1:0] sq5_reg [3];
    logic [CW-1:0]   cr5_reg;
    logic [SW-1:0]   sum6_reg;
    logic [CW-1:0]   cr6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i] <= sa4_reg[i] * sa4_reg[i];
            end
            cr5_reg  <= {sa4_reg[0], sa4_reg[1], sa4_reg[2], neg4_reg, zero4_reg, side4_reg};
            sum6_reg <= SW'(sq5_reg[0]) + SW'(sq5_reg[1]) + SW'(sq5_reg[2]);
            cr6_reg  <= cr5_reg;
        end
    end

    // square root, one result bit per stage
    logic [SW-1:0]  rem_reg [NSQ];
    logic [SW-1:0]  root_reg [NSQ];
    logic [CW-1:0]  sq_cr_reg [NSQ];
    logic [NSQ-1:0] sq_v_reg;

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (NSQ - 1 - k));
        logic [SW-1:0] rem_in;
        logic [SW-1:0] root_in;
        logic [CW-1:0] cr_in;
        logic          v_in;
        logic [SW-1:0] trial;
        logic [SW-1:0] rem_next;
        logic [SW-1:0] root_next;

        if (k == 0)
        begin : g_src
            assign rem_in  = sum6_reg;
            assign root_in = '0;
            assign cr_in   = cr6_reg;
            assign v_in    = vf_reg[5];
        end
        else
        begin : g_src
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign cr_in   = sq_cr_reg[k-1];
            assign v_in    = sq_v_reg[k-1];
        end

        always_comb
        begin
            trial = root_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = (root_in >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]   <= rem_next;
                root_reg[k]  <= root_next;
                sq_cr_reg[k] <= cr_in;
            end
        end
    end

    // restoring division of each magnitude by the length, one quotient bit per stage
    logic [DR-1:0] dr_reg [QW][3];
    logic [QW-1:0] q_reg [QW][3];
    logic [RW-1:0] mag_reg [QW];
    logic [TW-1:0] dcr_reg [QW];
    logic [QW-1:0] dv_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [DR-1:0] r_in [3];
        logic [QW-1:0] q_in [3];
        logic [RW-1:0] m_in;
        logic [TW-1:0] t_in;
        logic          v_in;
        logic [DR-1:0] r_next [3];
        logic [QW-1:0] q_next [3];

        if (j == 0)
        begin : g_src
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r_in[i] = DR'(sq_cr_reg[NSQ-1][CW-1-i*AW -: AW]);
                    q_in[i] = '0;
                end
            end
            assign m_in = root_reg[NSQ-1][RW-1:0];
            assign t_in = sq_cr_reg[NSQ-1][TW-1:0];
            assign v_in = sq_v_reg[NSQ-1];
        end
        else
        begin : g_src
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r_in[i] = {dr_reg[j-1][i][DR-2:0], 1'b0};
                    q_in[i] = q_reg[j-1][i];
                end
            end
            assign m_in = mag_reg[j-1];
            assign t_in = dcr_reg[j-1];
            assign v_in = dv_reg[j-1];
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (r_in[i] >= DR'(m_in))
                begin
                    r_next[i] = r_in[i] - DR'(m_in);
                    q_next[i] = {q_in[i][QW-2:0], 1'b1};
                end
                else
                begin
                    r_next[i] = r_in[i];
                    q_next[i] = {q_in[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dr_reg[j]  <= r_next;
                q_reg[j]   <= q_next;
                mag_reg[j] <= m_in;
                dcr_reg[j] <= t_in;
            end
        end
    end

    // final stage: signs back on, zero-length vectors stay zero
    logic [2:0]             dneg;
    logic                   dzero;
    logic signed [NW-1:0]   nvec_next [3];
    logic signed [NW-1:0]   nvec_reg [3];
    logic [SIDE_W-1:0]      sideo_reg;
    logic                   vo_reg;

    assign dneg  = dcr_reg[QW-1][SIDE_W+3 -: 3];
    assign dzero = dcr_reg[QW-1][SIDE_W];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dzero)
            begin
                nvec_next[i] = '0;
            end
            else if (dneg[i])
            begin
                nvec_next[i] = -NW'(q_reg[QW-1][i]);
            end
            else
            begin
                nvec_next[i] = NW'(q_reg[QW-1][i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= dv_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nvec_reg  <= nvec_next;
            sideo_reg <= dcr_reg[QW-1][SIDE_W-1:0];
        end
    end

    assign out_valid = vo_reg;
    assign nvec      = nvec_reg;
    assign side_out  = sideo_reg;

    // scaled length of a non-zero vector lands in [2^29, 2^31)
    `ASSERT_IMPLIES(a_root_range, sq_v_reg[NSQ-1] && !sq_cr_reg[NSQ-1][SIDE_W], root_reg[NSQ-1] >= (SW'(1) << (AW - 1)) && root_reg[NSQ-1] < (SW'(1) << RW))

    // division remainders end below the divisor
    `ASSERT_IMPLIES(a_rem_below, dv_reg[QW-1] && !dzero, dr_reg[QW-1][0] < DR'(mag_reg[QW-1]) && dr_reg[QW-1][1] < DR'(mag_reg[QW-1]) && dr_reg[QW-1][2] < DR'(mag_reg[QW-1]))

    // a unit component never exceeds one
    `ASSERT_NEVER(a_quot_bound, dv_reg[QW-1] && !dzero && (q_reg[QW-1][0] > (QW'(1) << FRAC_BITS) || q_reg[QW-1][1] > (QW'(1) << FRAC_BITS) || q_reg[QW-1][2] > (QW'(1) << FRAC_BITS)))

endmodule

// File: hdl/look_at_view_matrix.sv
// look-at view matrix: throughput one item per cycle while the result is not stalled;
// each of the three normalisers runs a 31-stage square root and a
// (FRAC_BITS+1)-stage divider in the pipeline
// a stalled result freezes every stage, nothing is dropped or repeated
// reset clears only the valid bits, the data registers are left as they are
module look_at_view_matrix
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int NW  = FRAC_BITS + 2;
    localparam int ZW  = DATA_W + 1;
    localparam int P1W = DATA_W + NW;
    localparam int XW  = P1W + 1;
    localparam int P2W = 2 * NW;
    localparam int YW  = P2W + 1;
    localparam int PDW = DATA_W + NW;
    localparam int DW  = PDW + 2;
    localparam int S1W = 6 * DATA_W;
    localparam int S2W = 3 * DATA_W + 3 * NW;
    localparam int S3W = 3 * DATA_W + 6 * NW;

    logic en;
    logic result_valid_reg;

    assign en         = !result_valid_reg || !result_stall;
    assign item_stall = !en;

    // saturate a dot product after dropping the fraction toward zero
    function automatic logic signed [DATA_W-1:0] sat_shift(input logic signed [DW-1:0] s);
        logic [DW-1:0] mg;
        logic [DW-1:0] lim;
        mg = s[DW-1] ? DW'(-s) : DW'(s);
        mg = mg >> FRAC_BITS;
        if (s[DW-1])
        begin
            lim = DW'(1) << (DATA_W - 1);
            if (mg > lim)
            begin
                mg = lim;
            end
            sat_shift = DATA_W'(-mg);
        end
        else
        begin
            lim = (DW'(1) << (DATA_W - 1)) - DW'(1);
            if (mg > lim)
            begin
                mg = lim;
            end
            sat_shift = DATA_W'(mg);
        end
    endfunction

    // input stage: forward vector before normalising
    logic signed [DATA_W-1:0] eye0_reg [3];
    logic signed [DATA_W-1:0] up0_reg [3];
    logic signed [ZW-1:0]     z0_reg [3];
    logic                     v0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eye0_reg[0] <= item.eye_x;
            eye0_reg[1] <= item.eye_y;
            eye0_reg[2] <= item.eye_z;
            up0_reg[0]  <= item.upward_x;
            up0_reg[1]  <= item.upward_y;
            up0_reg[2]  <= item.upward_z;
            z0_reg[0]   <= ZW'(item.eye_x) - ZW'(item.look_x);
            z0_reg[1]   <= ZW'(item.eye_y) - ZW'(item.look_y);
            z0_reg[2]   <= ZW'(item.eye_z) - ZW'(item.look_z);
        end
    end

    // forward normaliser, eye and up ride alongside
    logic                     n1_valid;
    logic signed [NW-1:0]     zn1 [3];
    logic [S1W-1:0]           side1_out;
    logic signed [DATA_W-1:0] eye1 [3];
    logic signed [DATA_W-1:0] up1 [3];

    lvm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (ZW),
        .SIDE_W    (S1W)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .vec       (z0_reg),
        .side_in   ({eye0_reg[0], eye0_reg[1], eye0_reg[2],
                     up0_reg[0], up0_reg[1], up0_reg[2]}),
        .out_valid (n1_valid),
        .nvec      (zn1),
        .side_out  (side1_out)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye1[i] = side1_out[S1W-1-i*DATA_W -: DATA_W];
            up1[i]  = side1_out[3*DATA_W-1-i*DATA_W -: DATA_W];
        end
    end

    // side vector: products, then differences
    logic signed [P1W-1:0]    pu_reg [6];
    logic signed [DATA_W-1:0] eye_c1a_reg [3];
    logic signed [NW-1:0]     zn_c1a_reg [3];
    logic                     c1a_v_reg;
    logic signed [XW-1:0]     x_reg [3];
    logic signed [DATA_W-1:0] eye_c1b_reg [3];
    logic signed [NW-1:0]     zn_c1b_reg [3];
    logic                     c1b_v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg[0]   <= up1[2] * zn1[1];
            pu_reg[1]   <= up1[1] * zn1[2];
            pu_reg[2]   <= up1[0] * zn1[2];
            pu_reg[3]   <= up1[2] * zn1[0];
            pu_reg[4]   <= up1[1] * zn1[0];
            pu_reg[5]   <= up1[0] * zn1[1];
            eye_c1a_reg <= eye1;
            zn_c1a_reg  <= zn1;
            for (int i = 0; i < 3; i++)
            begin
                x_reg[i] <= XW'(pu_reg[2*i]) - XW'(pu_reg[2*i+1]);
            end
            eye_c1b_reg <= eye_c1a_reg;
            zn_c1b_reg  <= zn_c1a_reg;
        end
    end

    logic                     n2_valid;
    logic signed [NW-1:0]     xn2 [3];
    logic [S2W-1:0]           side2_out;
    logic signed [DATA_W-1:0] eye2 [3];
    logic signed [NW-1:0]     zn2 [3];

    lvm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (XW),
        .SIDE_W    (S2W)
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1b_v_reg),
        .vec       (x_reg),
        .side_in   ({eye_c1b_reg[0], eye_c1b_reg[1], eye_c1b_reg[2],
                     zn_c1b_reg[0], zn_c1b_reg[1], zn_c1b_reg[2]}),
        .out_valid (n2_valid),
        .nvec      (xn2),
        .side_out  (side2_out)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye2[i] = side2_out[S2W-1-i*DATA_W -: DATA_W];
            zn2[i]  = side2_out[3*NW-1-i*NW -: NW];
        end
    end

    // recomputed up from the unit forward and side vectors
    logic signed [P2W-1:0]    pz_reg [6];
    logic signed [DATA_W-1:0] eye_c2a_reg [3];
    logic signed [NW-1:0]     zn_c2a_reg [3];
    logic signed [NW-1:0]     xn_c2a_reg [3];
    logic                     c2a_v_reg;
    logic signed [YW-1:0]     y_reg [3];
    logic signed [DATA_W-1:0] eye_c2b_reg [3];
    logic signed [NW-1:0]     zn_c2b_reg [3];
    logic signed [NW-1:0]     xn_c2b_reg [3];
    logic                     c2b_v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pz_reg[0]   <= zn2[2] * xn2[1];
            pz_reg[1]   <= zn2[1] * xn2[2];
            pz_reg[2]   <= zn2[0] * xn2[2];
            pz_reg[3]   <= zn2[2] * xn2[0];
            pz_reg[4]   <= zn2[1] * xn2[0];
            pz_reg[5]   <= zn2[0] * xn2[1];
            eye_c2a_reg <= eye2;
            zn_c2a_reg  <= zn2;
            xn_c2a_reg  <= xn2;
            for (int i = 0; i < 3; i++)
            begin
                y_reg[i] <= YW'(pz_reg[2*i]) - YW'(pz_reg[2*i+1]);
            end
            eye_c2b_reg <= eye_c2a_reg;
            zn_c2b_reg  <= zn_c2a_reg;
            xn_c2b_reg  <= xn_c2a_reg;
        end
    end

    logic                     n3_valid;
    logic signed [NW-1:0]     yn3 [3];
    logic [S3W-1:0]           side3_out;
    logic signed [DATA_W-1:0] eye3 [3];
    logic signed [NW-1:0]     zn3 [3];
    logic signed [NW-1:0]     xn3 [3];

    lvm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (YW),
        .SIDE_W    (S3W)
    ) u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2b_v_reg),
        .vec       (y_reg),
        .side_in   ({eye_c2b_reg[0], eye_c2b_reg[1], eye_c2b_reg[2],
                     zn_c2b_reg[0], zn_c2b_reg[1], zn_c2b_reg[2],
                     xn_c2b_reg[0], xn_c2b_reg[1], xn_c2b_reg[2]}),
        .out_valid (n3_valid),
        .nvec      (yn3),
        .side_out  (side3_out)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye3[i] = side3_out[S3W-1-i*DATA_W -: DATA_W];
            zn3[i]  = side3_out[6*NW-1-i*NW -: NW];
            xn3[i]  = side3_out[3*NW-1-i*NW -: NW];
        end
    end

    // translations: products, sums, then saturate into the result register
    logic signed [PDW-1:0] dp_reg [9];
    logic signed [NW-1:0]  xn_da_reg [3];
    logic signed [NW-1:0]  yn_da_reg [3];
    logic signed [NW-1:0]  zn_da_reg [3];
    logic                  da_v_reg;
    logic signed [DW-1:0]  s_reg [3];
    logic signed [NW-1:0]  xn_db_reg [3];
    logic signed [NW-1:0]  yn_db_reg [3];
    logic signed [NW-1:0]  zn_db_reg [3];
    logic                  db_v_reg;
    result_t               result_next;
    result_t               result_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i]   <= xn3[i] * eye3[i];
                dp_reg[3+i] <= yn3[i] * eye3[i];
                dp_reg[6+i] <= zn3[i] * eye3[i];
            end
            xn_da_reg <= xn3;
            yn_da_reg <= yn3;
            zn_da_reg <= zn3;
            s_reg[0]  <= -(DW'(dp_reg[0]) + DW'(dp_reg[1]) + DW'(dp_reg[2]));
            s_reg[1]  <= -(DW'(dp_reg[3]) + DW'(dp_reg[4]) + DW'(dp_reg[5]));
            s_reg[2]  <= DW'(dp_reg[6]) + DW'(dp_reg[7]) + DW'(dp_reg[8]);
            xn_db_reg <= xn_da_reg;
            yn_db_reg <= yn_da_reg;
            zn_db_reg <= zn_da_reg;
        end
    end

    always_comb
    begin
        result_next.row0_col0 = DATA_W'(xn_db_reg[0]);
        result_next.row0_col1 = DATA_W'(xn_db_reg[1]);
        result_next.row0_col2 = DATA_W'(xn_db_reg[2]);
        result_next.row0_col3 = sat_shift(s_reg[0]);
        result_next.row1_col0 = DATA_W'(yn_db_reg[0]);
        result_next.row1_col1 = DATA_W'(yn_db_reg[1]);
        result_next.row1_col2 = DATA_W'(yn_db_reg[2]);
        result_next.row1_col3 = sat_shift(s_reg[1]);
        result_next.row2_col0 = DATA_W'(-zn_db_reg[0]);
        result_next.row2_col1 = DATA_W'(-zn_db_reg[1]);
        result_next.row2_col2 = DATA_W'(-zn_db_reg[2]);
        result_next.row2_col3 = sat_shift(s_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    // valid bits follow the data through the glue stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg           <= 1'b0;
            c1a_v_reg        <= 1'b0;
            c1b_v_reg        <= 1'b0;
            c2a_v_reg        <= 1'b0;
            c2b_v_reg        <= 1'b0;
            da_v_reg         <= 1'b0;
            db_v_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg           <= item_valid;
            c1a_v_reg        <= n1_valid;
            c1b_v_reg        <= c1a_v_reg;
            c2a_v_reg        <= n2_valid;
            c2b_v_reg        <= c2a_v_reg;
            da_v_reg         <= n3_valid;
            db_v_reg         <= da_v_reg;
            result_valid_reg <= db_v_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
